// ===== rtl/wpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wipe pattern generator package
// Shared widths, register codes, payload types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package wpg_pkg;

   localparam int PAT_W      = 5;
   localparam int PROG_W     = 17;
   localparam int DIM_W      = 13;
   localparam int COORD_W    = 12;
   localparam int PIX_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [PROG_W-1:0] PROG_FULL    = 17'h10000;
   localparam logic [DIM_W-1:0]  RESET_WIDTH  = 13'd1920;
   localparam logic [DIM_W-1:0]  RESET_HEIGHT = 13'd1080;

   localparam int DEF_MAX_DIM      = 4096;
   localparam int DEF_BLIND_BANDS  = 8;
   localparam int DEF_CHECKER_CELL = 8;

   // Checker hash constants.
   localparam logic [31:0] HASH_MUL_X = 32'h9E3779B1;
   localparam logic [31:0] HASH_MUL_Y = 32'h85EBCA77;
   localparam logic [31:0] HASH_MUL_S = 32'hC2B2AE3D;
   localparam logic [31:0] HASH_MIX   = 32'h2545F491;
   localparam logic [31:0] HASH_SEED_TERM = 32'(64'd42 * 64'(HASH_MUL_S));
   localparam logic [7:0]  HASH_MOD   = 8'd255;

   // CORDIC geometry.
   localparam int CORDIC_STEPS     = 24;
   localparam int CORDIC_PER_STAGE = 3;
   localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
   localparam int CORDIC_W         = 36;

   // atan(2^-i) in 2^-32 turns.
   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

   typedef enum logic [PAT_W-1:0] {
      PAT_LEFT         = 5'd0,
      PAT_RIGHT        = 5'd1,
      PAT_UP           = 5'd2,
      PAT_DOWN         = 5'd3,
      PAT_CORNER_TL    = 5'd4,
      PAT_CORNER_TR    = 5'd5,
      PAT_CORNER_BL    = 5'd6,
      PAT_CORNER_BR    = 5'd7,
      PAT_IRIS_IN      = 5'd8,
      PAT_IRIS_OUT     = 5'd9,
      PAT_CIRCLE       = 5'd10,
      PAT_DIAMOND      = 5'd11,
      PAT_CLOCK        = 5'd12,
      PAT_CLOCK_REV    = 5'd13,
      PAT_BLINDS_H     = 5'd14,
      PAT_BLINDS_V     = 5'd15,
      PAT_CHECKER      = 5'd16,
      PAT_BARN_H       = 5'd17,
      PAT_BARN_V       = 5'd18,
      PAT_CUT          = 5'd19
   } pattern_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN  = 2'd0,
      CSR_PROGRESS = 2'd1,
      CSR_WIDTH    = 2'd2,
      CSR_HEIGHT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] pix_x;
      logic [COORD_W-1:0] pix_y;
      logic [PIX_W-1:0]   pixel_a;
      logic [PIX_W-1:0]   pixel_b;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             shows_incoming;
   } rsp_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] cx;
      logic signed [CORDIC_W-1:0] cy;
      logic [31:0]                acc;
      logic                       zero;
   } cordic_type;

endpackage

// ===== rtl/wipe_pattern_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wipe pattern generator
// Selects the outgoing or incoming pixel per the coverage of a wipe pattern.
// ----------------------------------------------------------------------------
// A request passes through the pixel pipeline registers and then the response register to rsp.
// Throughput: one request per cycle unless rsp_stall holds a response; the 8-stage
// CORDIC sets the depth, and every stage advances together.
// Reset: synchronous; the registers return to pattern 0, progress 0, 1920x1080,
// and all pipeline valid bits clear.
// ----------------------------------------------------------------------------
module wipe_pattern_generator_unit #(
   parameter int MAX_DIM      = wpg_pkg::DEF_MAX_DIM,
   parameter int BLIND_BANDS  = wpg_pkg::DEF_BLIND_BANDS,
   parameter int CHECKER_CELL = wpg_pkg::DEF_CHECKER_CELL
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  wpg_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wpg_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [wpg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wpg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wpg_pkg::*;

   localparam int CMPW        = 48;
   localparam int PIPE_DEPTH  = 10;
   localparam int DIM_MAX_VAL = 2 ** DIM_W - 1;
   localparam logic [DIM_W-1:0] DIM_LIMIT =
      DIM_W'((MAX_DIM > DIM_MAX_VAL) ? DIM_MAX_VAL : MAX_DIM);
   // Reciprocals for division by the band count and by the checker cell size.
   // They are exact over the operand ranges used below.
   localparam int BAND_SHIFT = 21;
   localparam logic [20:0] BAND_RECIP =
      21'((2 ** BAND_SHIFT + BLIND_BANDS - 1) / BLIND_BANDS);
   localparam logic [DIM_W:0] BAND_ROUND = (DIM_W + 1)'(BLIND_BANDS - 1);
   localparam int CELL_SHIFT = 19;
   localparam logic [18:0] CELL_RECIP =
      19'((2 ** CELL_SHIFT + CHECKER_CELL - 1) / CHECKER_CELL);

   typedef logic signed [CMPW-1:0] cmp_type;

   typedef struct packed {
      logic [COORD_W-1:0] pix_x;
      logic [COORD_W-1:0] pix_y;
      logic [PIX_W-1:0]   pixel_a;
      logic [PIX_W-1:0]   pixel_b;
      logic [15:0]        dx;
      logic [15:0]        dy;
      logic [15:0]        adx;
      logic [15:0]        ady;
      logic [15:0]        rx;
      logic [15:0]        ry;
      logic [15:0]        ax;
      logic [15:0]        ay;
      logic [COORD_W-1:0] xq;
      logic [COORD_W-1:0] yq;
      logic [31:0]        hash;
      logic [9:0]         bsum;
      logic [27:0]        r2;
      logic [DIM_W-1:0]   rem_x;
      logic [DIM_W-1:0]   rem_y;
      logic               hit_simple;
      logic               hit_circle;
      logic               hit_check;
      logic               hit_bh;
      logic               hit_bw;
   } pix_type;

   // Configuration registers.
   pattern_type         pattern_ff;
   logic [PROG_W-1:0]   progress_ff;
   logic [DIM_W-1:0]    width_ff;
   logic [DIM_W-1:0]    height_ff;

   // Values derived from configuration. A request sent after a write must not reach
   // the stages reading them before they settle; the block does not enforce this.
   logic [PROG_W-1:0]   p_eff_ff;
   logic [DIM_W-1:0]    width_c_ff;
   logic [DIM_W-1:0]    height_c_ff;
   logic [29:0]         pw_ff;
   logic [29:0]         ph_ff;
   logic [30:0]         pwh_ff;
   logic [29:0]         qw_ff;
   logic [29:0]         qh_ff;
   logic [31:0]         pp_ff;
   logic [26:0]         d2_ff;
   logic [DIM_W-1:0]    band_h_ff;
   logic [DIM_W-1:0]    band_w_ff;
   logic [59:0]         pd_ff;
   logic [28:0]         pbh_ff;
   logic [28:0]         pbw_ff;
   logic [34:0]         band_h_prod;
   logic [34:0]         band_w_prod;

   // Pixel pipeline.
   logic                valid_ff [PIPE_DEPTH];
   pix_type             st_ff    [PIPE_DEPTH];
   pix_type             st_in    [PIPE_DEPTH];
   logic                advance;
   logic [15:0]         turn;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                rsp_valid_ff;

   // The whole pipeline moves whenever the output register is free or drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------------
   // Configuration port.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= PAT_LEFT;
         progress_ff <= '0;
         width_ff    <= RESET_WIDTH;
         height_ff   <= RESET_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN:  pattern_ff  <= pattern_type'(csr_wdata[PAT_W-1:0]);
            CSR_PROGRESS: progress_ff <= csr_wdata[PROG_W-1:0];
            CSR_WIDTH:    width_ff    <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT:   height_ff   <= csr_wdata[DIM_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Derived configuration, three register levels.
   // ---------------------------------------------------------------------------
   assign band_h_prod = 35'((DIM_W + 1)'(height_c_ff) + BAND_ROUND) * 35'(BAND_RECIP);
   assign band_w_prod = 35'((DIM_W + 1)'(width_c_ff) + BAND_ROUND) * 35'(BAND_RECIP);

   always_ff @(posedge clock) begin
      // Level one: clamping.
      p_eff_ff    <= (progress_ff > PROG_FULL) ? PROG_FULL : progress_ff;
      width_c_ff  <= (width_ff == '0) ? DIM_W'(1) :
                     (width_ff > DIM_LIMIT) ? DIM_LIMIT : width_ff;
      height_c_ff <= (height_ff == '0) ? DIM_W'(1) :
                     (height_ff > DIM_LIMIT) ? DIM_LIMIT : height_ff;
      // Level two: products with the frame size, and the band sizes.
      pw_ff     <= 30'(p_eff_ff) * 30'(width_c_ff);
      ph_ff     <= 30'(p_eff_ff) * 30'(height_c_ff);
      pwh_ff    <= 31'(p_eff_ff) * (31'(width_c_ff) + 31'(height_c_ff));
      qw_ff     <= 30'(PROG_FULL - p_eff_ff) * 30'(width_c_ff);
      qh_ff     <= 30'(PROG_FULL - p_eff_ff) * 30'(height_c_ff);
      pp_ff     <= 32'(p_eff_ff[15:0]) * 32'(p_eff_ff[15:0]);
      d2_ff     <= 27'(27'(width_c_ff) * 27'(width_c_ff)
                     + 27'(height_c_ff) * 27'(height_c_ff));
      band_h_ff <= band_h_prod[BAND_SHIFT + DIM_W - 1:BAND_SHIFT];
      band_w_ff <= band_w_prod[BAND_SHIFT + DIM_W - 1:BAND_SHIFT];
      // Level three: circle radius bound and blind thresholds.
      pd_ff     <= 60'(pp_ff) * 60'(d2_ff);
      pbh_ff    <= 29'(p_eff_ff) * 29'(band_h_ff);
      pbw_ff    <= 29'(p_eff_ff) * 29'(band_w_ff);
   end

   // ---------------------------------------------------------------------------
   // Pixel pipeline datapath.
   // ---------------------------------------------------------------------------
   function automatic cmp_type sx(input logic [15:0] v);
      return cmp_type'($signed(v));
   endfunction

   always_comb begin
      logic signed [15:0] xs;
      logic signed [15:0] ys;
      logic signed [15:0] ws;
      logic signed [15:0] hs;
      logic signed [15:0] dxs;
      logic signed [15:0] dys;
      logic signed [31:0] sqx;
      logic signed [31:0] sqy;
      logic [30:0]        xprod;
      logic [30:0]        yprod;
      logic [31:0]        h;
      cmp_type            l_rx;
      cmp_type            l_ry;
      cmp_type            l_ax;
      cmp_type            l_ay;
      cmp_type            l_adx;
      cmp_type            l_ady;
      cmp_type            l_corner;
      cmp_type            l_diam;
      logic               in_box;
      logic               out_box;
      logic [8:0]         fold;
      logic [7:0]         hmod;
      logic [PROG_W-1:0]  thr;
      logic [DIM_W-1:0]   rx_t;
      logic [DIM_W-1:0]   ry_t;
      int                 bit_pos;

      st_in[0]         = '0;
      st_in[0].pix_x   = req_data.pix_x;
      st_in[0].pix_y   = req_data.pix_y;
      st_in[0].pixel_a = req_data.pixel_a;
      st_in[0].pixel_b = req_data.pixel_b;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         st_in[k] = st_ff[k-1];
      end

      // Stage 1: twice the offsets from the centre and the edges, cell index.
      xs = $signed({4'b0, st_ff[0].pix_x});
      ys = $signed({4'b0, st_ff[0].pix_y});
      ws = $signed({3'b0, width_c_ff});
      hs = $signed({3'b0, height_c_ff});
      dxs = (xs <<< 1) + 16'sd1 - ws;
      dys = (ys <<< 1) + 16'sd1 - hs;
      st_in[1].dx  = dxs;
      st_in[1].dy  = dys;
      st_in[1].adx = dxs[15] ? -dxs : dxs;
      st_in[1].ady = dys[15] ? -dys : dys;
      st_in[1].rx  = ((ws - xs) <<< 1) - 16'sd1;
      st_in[1].ry  = ((hs - ys) <<< 1) - 16'sd1;
      st_in[1].ax  = (xs <<< 1) + 16'sd1;
      st_in[1].ay  = (ys <<< 1) + 16'sd1;
      xprod = 31'(st_ff[0].pix_x) * 31'(CELL_RECIP);
      yprod = 31'(st_ff[0].pix_y) * 31'(CELL_RECIP);
      st_in[1].xq    = xprod[CELL_SHIFT + COORD_W - 1:CELL_SHIFT];
      st_in[1].yq    = yprod[CELL_SHIFT + COORD_W - 1:CELL_SHIFT];
      st_in[1].rem_x = '0;
      st_in[1].rem_y = '0;

      // Stage 2: linear pattern tests, squared radius, first hash round.
      l_rx  = sx(st_ff[1].rx) <<< 16;
      l_ry  = sx(st_ff[1].ry) <<< 16;
      l_ax  = sx(st_ff[1].ax) <<< 16;
      l_ay  = sx(st_ff[1].ay) <<< 16;
      l_adx = sx(st_ff[1].adx) <<< 16;
      l_ady = sx(st_ff[1].ady) <<< 16;
      l_corner = '0;
      case (pattern_ff) inside
         PAT_CORNER_TL: l_corner = (sx(st_ff[1].ax) + sx(st_ff[1].ay)) <<< 16;
         PAT_CORNER_TR: l_corner = (sx(st_ff[1].rx) + sx(st_ff[1].ay)) <<< 16;
         PAT_CORNER_BL: l_corner = (sx(st_ff[1].ax) + sx(st_ff[1].ry)) <<< 16;
         default:       l_corner = (sx(st_ff[1].rx) + sx(st_ff[1].ry)) <<< 16;
      endcase
      l_diam  = (sx(st_ff[1].adx) + sx(st_ff[1].ady)) <<< 16;
      in_box  = (l_adx < cmp_type'(pw_ff)) && (l_ady < cmp_type'(ph_ff));
      out_box = (l_adx < cmp_type'(qw_ff)) && (l_ady < cmp_type'(qh_ff));
      case (pattern_ff) inside
         PAT_LEFT:     st_in[2].hit_simple = l_rx <= cmp_type'({pw_ff, 1'b0});
         PAT_RIGHT:    st_in[2].hit_simple = l_ax <= cmp_type'({pw_ff, 1'b0});
         PAT_UP:       st_in[2].hit_simple = l_ry <= cmp_type'({ph_ff, 1'b0});
         PAT_DOWN:     st_in[2].hit_simple = l_ay <= cmp_type'({ph_ff, 1'b0});
         PAT_CORNER_TL, PAT_CORNER_TR, PAT_CORNER_BL, PAT_CORNER_BR:
            st_in[2].hit_simple = l_corner <= cmp_type'({pwh_ff, 1'b0});
         PAT_IRIS_IN:  st_in[2].hit_simple = in_box;
         PAT_IRIS_OUT: st_in[2].hit_simple = !out_box;
         PAT_DIAMOND:  st_in[2].hit_simple = l_diam < cmp_type'(pwh_ff);
         PAT_BARN_H:   st_in[2].hit_simple = l_adx >= cmp_type'(qw_ff);
         PAT_BARN_V:   st_in[2].hit_simple = l_ady >= cmp_type'(qh_ff);
         default:      st_in[2].hit_simple = 1'b0;
      endcase
      sqx = $signed(st_ff[1].dx) * $signed(st_ff[1].dx);
      sqy = $signed(st_ff[1].dy) * $signed(st_ff[1].dy);
      st_in[2].r2   = 28'(sqx + sqy);
      st_in[2].hash = 32'(st_ff[1].xq) * HASH_MUL_X + 32'(st_ff[1].yq) * HASH_MUL_Y
                      + HASH_SEED_TERM;

      // Stage 3: circle test, hash mix.
      st_in[3].hit_circle = {st_ff[2].r2, 32'd0} < pd_ff;
      h = st_ff[2].hash;
      st_in[3].hash = h ^ (h >> 15);

      // Stage 4: hash multiply.
      st_in[4].hash = st_ff[3].hash * HASH_MIX;

      // Stage 5: final mix, then the byte sum (256 is 1 modulo 255).
      h = st_ff[4].hash ^ (st_ff[4].hash >> 13);
      st_in[5].hash = h;
      st_in[5].bsum = 10'(h[7:0]) + 10'(h[15:8]) + 10'(h[23:16]) + 10'(h[31:24]);

      // Stage 6: reduce modulo 255 and compare with the cell threshold.
      fold = 9'(st_ff[5].bsum[7:0]) + 9'(st_ff[5].bsum[9:8]);
      hmod = (fold >= 9'(HASH_MOD)) ? 8'(fold - 9'(HASH_MOD)) : fold[7:0];
      thr  = {9'(hmod) + 9'd1, 8'd0};
      st_in[6].hit_check = p_eff_ff >= thr;

      // Stages 2 to 7: row and column remainders by the band size, two
      // restoring steps per stage, most significant coordinate bit first.
      for (int k = 2; k < 8; k++) begin
         rx_t = st_ff[k-1].rem_x;
         ry_t = st_ff[k-1].rem_y;
         for (int j = 0; j < 2; j++) begin
            bit_pos = COORD_W - 1 - (2 * (k - 2) + j);
            rx_t = {rx_t[DIM_W-2:0], st_ff[k-1].pix_x[bit_pos]};
            ry_t = {ry_t[DIM_W-2:0], st_ff[k-1].pix_y[bit_pos]};
            if (rx_t >= band_w_ff) begin
               rx_t = rx_t - band_w_ff;
            end
            if (ry_t >= band_h_ff) begin
               ry_t = ry_t - band_h_ff;
            end
         end
         st_in[k].rem_x = rx_t;
         st_in[k].rem_y = ry_t;
      end

      // Stage 8: blind tests.
      st_in[8].hit_bh = {1'b0, st_ff[7].rem_y[COORD_W-1:0], 1'b1, 16'd0}
                        <= {pbh_ff, 1'b0};
      st_in[8].hit_bw = {1'b0, st_ff[7].rem_x[COORD_W-1:0], 1'b1, 16'd0}
                        <= {pbw_ff, 1'b0};
   end

   // The clock angle runs beside stages 2 to 9; its input is the result of stage 1.
   wpg_cordic u_cordic (
      .clock  (clock),
      .enable (advance),
      .up     (16'(-$signed(st_ff[1].dy))),
      .right  (st_ff[1].dx),
      .turn   (turn)
   );

   // Final choice. The progress ends override every pattern, the hard cut too.
   always_comb begin
      logic sel;
      logic [15:0] turn_rev;
      turn_rev = 16'd0 - turn;
      if (p_eff_ff == '0) begin
         sel = 1'b0;
      end else if (p_eff_ff >= PROG_FULL) begin
         sel = 1'b1;
      end else begin
         case (pattern_ff) inside
            PAT_LEFT, PAT_RIGHT, PAT_UP, PAT_DOWN, PAT_CORNER_TL, PAT_CORNER_TR,
            PAT_CORNER_BL, PAT_CORNER_BR, PAT_IRIS_IN, PAT_IRIS_OUT, PAT_DIAMOND,
            PAT_BARN_H, PAT_BARN_V:
                          sel = st_ff[PIPE_DEPTH-1].hit_simple;
            PAT_CIRCLE:    sel = st_ff[PIPE_DEPTH-1].hit_circle;
            PAT_CLOCK:     sel = {1'b0, turn} < p_eff_ff;
            PAT_CLOCK_REV: sel = {1'b0, turn_rev} < p_eff_ff;
            PAT_BLINDS_H:  sel = st_ff[PIPE_DEPTH-1].hit_bh;
            PAT_BLINDS_V:  sel = st_ff[PIPE_DEPTH-1].hit_bw;
            PAT_CHECKER:   sel = st_ff[PIPE_DEPTH-1].hit_check;
            default:       sel = 1'b0;
         endcase
      end
      rsp_in.shows_incoming = sel;
      rsp_in.pixel_out = sel ? st_ff[PIPE_DEPTH-1].pixel_b : st_ff[PIPE_DEPTH-1].pixel_a;
   end

   // ---------------------------------------------------------------------------
   // Pipeline registers. Valid bits reset; payload does not.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rsp_valid_ff <= valid_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff  <= st_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/wpg_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wipe pattern generator clock angle unit
// Pipelined vectoring CORDIC giving a clockwise turn fraction from straight up.
// ----------------------------------------------------------------------------
module wpg_cordic (
   input  logic        clock,
   input  logic        enable,
   input  logic [15:0] up,
   input  logic [15:0] right,
   output logic [15:0] turn
);
   import wpg_pkg::*;

   cordic_type st_ff [CORDIC_STAGES];
   cordic_type st_in [CORDIC_STAGES];
   cordic_type init;

   function automatic cordic_type cordic_step(input cordic_type s, input logic [4:0] idx);
      cordic_type r;
      logic signed [CORDIC_W-1:0] xs;
      logic signed [CORDIC_W-1:0] ys;
      xs = s.cx >>> idx;
      ys = s.cy >>> idx;
      r  = s;
      if (!s.cy[CORDIC_W-1]) begin
         r.cx  = s.cx + ys;
         r.cy  = s.cy - xs;
         r.acc = s.acc + ATAN_TURNS[idx];
      end else begin
         r.cx  = s.cx - ys;
         r.cy  = s.cy + xs;
         r.acc = s.acc - ATAN_TURNS[idx];
      end
      return r;
   endfunction

   // Rotate the lower half plane by half a turn so the iterations converge.
   always_comb begin
      init.zero = (up == 16'd0) && (right == 16'd0);
      init.cx   = CORDIC_W'($signed(up)) <<< 16;
      init.cy   = CORDIC_W'($signed(right)) <<< 16;
      init.acc  = 32'd0;
      if (init.cx[CORDIC_W-1]) begin
         init.cx  = -init.cx;
         init.cy  = -init.cy;
         init.acc = 32'h80000000;
      end
   end

   always_comb begin
      cordic_type cur;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         cur = (k == 0) ? init : st_ff[k-1];
         for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
            cur = cordic_step(cur, 5'(k * CORDIC_PER_STAGE + j));
         end
         st_in[k] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff <= st_in;
      end
   end

   assign turn = st_ff[CORDIC_STAGES-1].zero ? 16'd0 : st_ff[CORDIC_STAGES-1].acc[31:16];

endmodule

// ===== dv/wipe_pattern_generator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wipe pattern generator testbench
// Streams pixel requests through the unit under many pattern, progress and
// frame size settings, and checks every response against an in-bench predictor
// of the wipe coverage tests or a typed-in result, with random idling on both sides.
// ----------------------------------------------------------------------------
module wipe_pattern_generator_unit_tb;
   import wpg_pkg::*;

   // Code outside the pattern catalog; the unit must treat it as a hard cut.
   localparam logic [PAT_W-1:0] PAT_UNUSED = 5'd31;
   localparam int FULL = 65536;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the unit's registers, updated as they are written.
   logic [PAT_W-1:0]  cfg_pattern = 5'd0;
   logic [PROG_W-1:0] cfg_progress = '0;
   logic [DIM_W-1:0]  cfg_width = RESET_WIDTH;
   logic [DIM_W-1:0]  cfg_height = RESET_HEIGHT;

   rsp_type expected_pixels[$];
   int      failures = 0;
   bit      idling_on = 1'b1;
   int      rsp_hold = 0;

   wipe_pattern_generator_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Clamp a size register to the legal 1..MAX_DIM range.
   function automatic longint frame_dim(logic [DIM_W-1:0] v);
      if (v < 1) return 1;
      if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
      return v;
   endfunction

   // Clockwise angle from straight up as a 16-bit fraction of a turn, found by
   // 24 vectoring steps. The arithmetic shift of a longint is a floor shift.
   function automatic logic [15:0] clock_angle(longint up, longint right);
      longint cx, cy, xs, ys;
      logic [31:0] acc;
      acc = 32'h0;
      if (up == 0 && right == 0) return 16'h0;
      cx = up * 65536;
      cy = right * 65536;
      if (cx < 0) begin
         cx = -cx;
         cy = -cy;
         acc = 32'h80000000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy >= 0) begin
            cx = cx + ys;
            cy = cy - xs;
            acc = acc + ATAN_TURNS[i];
         end else begin
            cx = cx - ys;
            cy = cy + xs;
            acc = acc - ATAN_TURNS[i];
         end
      end
      return acc[31:16];
   endfunction

   // Hash of a checker cell; all products wrap at 32 bits.
   function automatic logic [31:0] cell_hash(logic [31:0] cx, logic [31:0] cy);
      logic [31:0] hv;
      hv = cx * HASH_MUL_X + cy * HASH_MUL_Y + 32'd42 * HASH_MUL_S;
      hv = hv ^ (hv >> 15);
      hv = hv * HASH_MIX;
      hv = hv ^ (hv >> 13);
      return hv;
   endfunction

   // Coverage test of one pattern at a pixel centre, for progress strictly
   // between the two ends.
   function automatic bit pattern_covers(logic [PAT_W-1:0] pat, longint x, longint y,
                                         longint w, longint h, longint p);
      longint dx, dy, q, cx, cy, band;
      longint unsigned r2, d2, pp;
      logic [15:0] t;
      logic [31:0] hv;
      dx = 2 * x + 1 - w;
      dy = 2 * y + 1 - h;
      q = FULL - p;
      case (pat)
         PAT_LEFT:  return (2 * (w - x) - 1) * FULL <= 2 * p * w;
         PAT_RIGHT: return (2 * x + 1) * FULL <= 2 * p * w;
         PAT_UP:    return (2 * (h - y) - 1) * FULL <= 2 * p * h;
         PAT_DOWN:  return (2 * y + 1) * FULL <= 2 * p * h;
         PAT_CORNER_TL, PAT_CORNER_TR, PAT_CORNER_BL, PAT_CORNER_BR: begin
            cx = (pat == PAT_CORNER_TL || pat == PAT_CORNER_BL) ?
                 (2 * x + 1) : (2 * (w - x) - 1);
            cy = (pat == PAT_CORNER_TL || pat == PAT_CORNER_TR) ?
                 (2 * y + 1) : (2 * (h - y) - 1);
            return (cx + cy) * FULL <= 2 * p * (w + h);
         end
         PAT_IRIS_IN:
            return ((dx < 0 ? -dx : dx) * FULL < p * w) &&
                   ((dy < 0 ? -dy : dy) * FULL < p * h);
         PAT_IRIS_OUT:
            return !(((dx < 0 ? -dx : dx) * FULL < q * w) &&
                     ((dy < 0 ? -dy : dy) * FULL < q * h));
         PAT_CIRCLE: begin
            r2 = dx * dx + dy * dy;
            d2 = w * w + h * h;
            pp = p * p;
            return r2 * FULL * FULL < pp * d2;
         end
         PAT_DIAMOND:
            return ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy)) * FULL < p * (w + h);
         PAT_CLOCK: return clock_angle(-dy, dx) < p;
         PAT_CLOCK_REV: begin
            t = 16'h0 - clock_angle(-dy, dx);
            return t < p;
         end
         PAT_BLINDS_H: begin
            band = (h + DEF_BLIND_BANDS - 1) / DEF_BLIND_BANDS;
            return (2 * (y % band) + 1) * FULL <= 2 * p * band;
         end
         PAT_BLINDS_V: begin
            band = (w + DEF_BLIND_BANDS - 1) / DEF_BLIND_BANDS;
            return (2 * (x % band) + 1) * FULL <= 2 * p * band;
         end
         PAT_CHECKER: begin
            hv = cell_hash(32'(x / DEF_CHECKER_CELL), 32'(y / DEF_CHECKER_CELL));
            return p >= (hv % 255 + 1) * 256;
         end
         PAT_BARN_H: return (dx < 0 ? -dx : dx) * FULL >= q * w;
         PAT_BARN_V: return (dy < 0 ? -dy : dy) * FULL >= q * h;
         default:    return 1'b0;
      endcase
   endfunction

   // Whether the incoming pixel is shown under the current register settings.
   function automatic bit shows_b(req_type r);
      longint p;
      p = (cfg_progress > FULL) ? FULL : cfg_progress;
      if (p == 0) return 1'b0;
      if (p >= FULL) return 1'b1;
      return pattern_covers(cfg_pattern, r.pix_x, r.pix_y, frame_dim(cfg_width),
                            frame_dim(cfg_height), p);
   endfunction

   // ------------------------------------------------------------------------
   // Driving tasks
   // ------------------------------------------------------------------------

   // One register write; the caller drops the write enable after the last one.
   task automatic write_reg(csr_index_type idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      case (idx)
         CSR_PATTERN:  cfg_pattern = value[PAT_W-1:0];
         CSR_PROGRESS: cfg_progress = value[PROG_W-1:0];
         CSR_WIDTH:    cfg_width = value[DIM_W-1:0];
         default:      cfg_height = value[DIM_W-1:0];
      endcase
   endtask

   // Stop sending, let every pending response come back, then let the
   // pipeline empty out before any register is touched.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (expected_pixels.size() == 0);
      repeat (12) @(posedge clock);
   endtask

   // Set all four registers, writing only those that change; the unit is
   // drained first whenever a write is needed.
   task automatic apply_settings(logic [PAT_W-1:0] pat, int prog, int wd, int ht);
      if (pat == cfg_pattern && prog == cfg_progress &&
          wd == cfg_width && ht == cfg_height) return;
      drain_pipeline();
      if (pat != cfg_pattern) write_reg(CSR_PATTERN, pat);
      if (prog != cfg_progress) write_reg(CSR_PROGRESS, prog);
      if (wd != cfg_width) write_reg(CSR_WIDTH, wd);
      if (ht != cfg_height) write_reg(CSR_HEIGHT, ht);
      csr_we <= 1'b0;
   endtask

   // Present one pixel request and hold it until accepted. A typed-in
   // selection, when given, stands in for the predictor.
   task automatic send_pixel(req_type r, bit sel_known, bit sel_typed);
      int gap;
      rsp_type exp_rsp;
      bit sel;
      gap = idling_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sel = sel_known ? sel_typed : shows_b(r);
      exp_rsp.shows_incoming = sel;
      exp_rsp.pixel_out = sel ? r.pixel_b : r.pixel_a;
      expected_pixels.push_back(exp_rsp);
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stall per response, and the checks.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("response with no request pending: pixel_out %h", rsp_data.pixel_out);
            failures++;
         end else begin
            if (rsp_data.shows_incoming !== expected_pixels[0].shows_incoming) begin
               $error("shows_incoming expected %0d actual %0d",
                      expected_pixels[0].shows_incoming, rsp_data.shows_incoming);
               failures++;
            end
            if (rsp_data.pixel_out !== expected_pixels[0].pixel_out) begin
               $error("pixel_out expected %h actual %h",
                      expected_pixels[0].pixel_out, rsp_data.pixel_out);
               failures++;
            end
            void'(expected_pixels.pop_front());
         end
         rsp_hold = idling_on ? $urandom_range(0, 7) : 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold > 0);
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   typedef struct {
      logic [PAT_W-1:0] pat;
      int  prog;
      int  wd;
      int  ht;
      int  x;
      int  y;
      bit  known;
      bit  sel;
   } directed_row;

   directed_row directed_rows[] = '{
      // Reset settings: progress 0 passes A, even at the largest coordinates.
      '{PAT_LEFT,      0,      1920, 1080, 0,    0,    1, 0},
      '{PAT_LEFT,      0,      1920, 1080, 4095, 4095, 1, 0},
      // Full progress passes B, also for the hard cut and above full range.
      '{PAT_LEFT,      65536,  1920, 1080, 5,    7,    1, 1},
      '{PAT_CUT,       65536,  64,   48,   3,    4,    1, 1},
      '{PAT_CUT,       131071, 64,   48,   63,   47,   1, 1},
      // Between the ends a hard cut, and any unused code, passes A.
      '{PAT_CUT,       32768,  64,   48,   10,   10,   1, 0},
      '{PAT_UNUSED,    32768,  64,   48,   10,   10,   1, 0},
      // A lone pixel sits at the clock centre, whose angle is zero.
      '{PAT_CLOCK,     1,      1,    1,    0,    0,    1, 1},
      '{PAT_LEFT,      32768,  64,   48,   20,   9,    0, 0},
      '{PAT_RIGHT,     32768,  8191, 48,   2047, 9,    0, 0},
      '{PAT_UP,        32768,  64,   48,   20,   23,   0, 0},
      '{PAT_DOWN,      32768,  64,   48,   20,   24,   0, 0},
      '{PAT_CORNER_TL, 32768,  64,   48,   30,   20,   0, 0},
      '{PAT_CORNER_TR, 32768,  64,   48,   30,   20,   0, 0},
      '{PAT_CORNER_BL, 32768,  64,   48,   30,   20,   0, 0},
      '{PAT_CORNER_BR, 32768,  64,   48,   30,   20,   0, 0},
      '{PAT_IRIS_IN,   32768,  64,   48,   40,   30,   0, 0},
      '{PAT_IRIS_OUT,  32768,  64,   48,   40,   30,   0, 0},
      // Circle tested at a pixel well outside the frame.
      '{PAT_CIRCLE,    32768,  64,   48,   4095, 4095, 0, 0},
      // Zero sizes act as one pixel.
      '{PAT_DIAMOND,   32768,  0,    0,    0,    0,    0, 0},
      '{PAT_CLOCK,     20000,  64,   48,   50,   10,   0, 0},
      '{PAT_CLOCK_REV, 20000,  64,   48,   50,   10,   0, 0},
      '{PAT_BLINDS_H,  32768,  64,   48,   7,    13,   0, 0},
      '{PAT_BLINDS_V,  32768,  64,   48,   13,   7,    0, 0},
      '{PAT_CHECKER,   32768,  4096, 4096, 4095, 2222, 0, 0},
      '{PAT_BARN_H,    32768,  64,   48,   2,    30,   0, 0},
      '{PAT_BARN_V,    32768,  64,   48,   40,   2,    0, 0}
   };

   function automatic int pick_progress();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return 65535;
         3:       return 65536;
         4:       return $urandom_range(65537, 131071);
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 1;
         2:       return 4096;
         3:       return $urandom_range(4097, 8191);
         4, 5:    return $urandom_range(1, 64);
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   initial begin
      req_type r;
      int wd, ht;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         apply_settings(directed_rows[i].pat, directed_rows[i].prog,
                        directed_rows[i].wd, directed_rows[i].ht);
         r.pix_x = COORD_W'(directed_rows[i].x);
         r.pix_y = COORD_W'(directed_rows[i].y);
         r.pixel_a = $urandom;
         r.pixel_b = $urandom;
         send_pixel(r, directed_rows[i].known, directed_rows[i].sel);
      end

      // Random phases, each under its own settings. Every fourth phase runs
      // with no idling on either side.
      for (int phase = 0; phase < 20; phase++) begin
         idling_on = (phase % 4 != 1);
         wd = pick_dim();
         ht = pick_dim();
         apply_settings(($urandom_range(0, 9) == 0) ? 5'($urandom_range(19, 31))
                                                     : 5'($urandom_range(0, 18)),
                        pick_progress(), wd, ht);
         for (int n = 0; n < 100; n++) begin
            // Mostly pixels inside the frame, the rest anywhere.
            if ($urandom_range(0, 4) != 0) begin
               r.pix_x = COORD_W'($urandom_range(0, 32'(frame_dim(cfg_width) - 1)));
               r.pix_y = COORD_W'($urandom_range(0, 32'(frame_dim(cfg_height) - 1)));
            end else begin
               r.pix_x = COORD_W'($urandom);
               r.pix_y = COORD_W'($urandom);
            end
            r.pixel_a = $urandom;
            r.pixel_b = $urandom;
            send_pixel(r, 1'b0, 1'b0);
         end
      end

      req_valid <= 1'b0;
      wait (expected_pixels.size() == 0);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Run limit, far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
